// File: sv/vsc_pkg.sv
package vsc_pkg;

  // Fixed field widths
  localparam int COORD_BITS = 20;
  localparam int DIM_BITS   = 11;
  localparam int IN_FIELD_W = 10;
  localparam int ADDR_W     = 30;
  localparam int TAG_W      = 32;
  localparam int SCALAR_W   = 48;
  localparam int VEC_W      = 3 * COORD_BITS;
  localparam int DIMS_W     = 3 * DIM_BITS;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;

  // Stream and configuration port widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  // Squared axis length fits 40 bits; split in halves for the product compare
  localparam int L2_W   = 2 * COORD_BITS;
  localparam int HALF_W = L2_W / 2;

  // Parameter defaults
  localparam int INDEX_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 8;

  // Shape kinds
  localparam logic [KIND_W-1:0] KIND_SPHERE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BOX     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUBGRID = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CYL     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_HALF    = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_INSIDE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTGRID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DEGEN   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALAR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAG    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 3'd6;

endpackage

// File: sv/vsc_prod_cmp.sv
module vsc_prod_cmp (
  input  logic                     clk,
  input  logic [1:0]               en,  // [0] partial products, [1] sums
  input  logic [vsc_pkg::L2_W-1:0] a,
  input  logic [vsc_pkg::L2_W-1:0] b,
  input  logic [vsc_pkg::L2_W-1:0] c,
  output logic                     le   // a*b <= c*c
);
  import vsc_pkg::*;

  localparam int PP_W  = 2 * HALF_W;
  localparam int SUM_W = 2 * L2_W;

  logic [PP_W-1:0]  ab_hh, ab_hl, ab_lh, ab_ll;
  logic [PP_W-1:0]  cc_hh, cc_hl, cc_ll;
  logic [SUM_W-1:0] ab_sum, cc_sum;

  // Form 20x20 partial products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ab_hh <= a[L2_W-1:HALF_W] * b[L2_W-1:HALF_W];
      ab_hl <= a[L2_W-1:HALF_W] * b[HALF_W-1:0];
      ab_lh <= a[HALF_W-1:0] * b[L2_W-1:HALF_W];
      ab_ll <= a[HALF_W-1:0] * b[HALF_W-1:0];
      cc_hh <= c[L2_W-1:HALF_W] * c[L2_W-1:HALF_W];
      cc_hl <= c[L2_W-1:HALF_W] * c[HALF_W-1:0];
      cc_ll <= c[HALF_W-1:0] * c[HALF_W-1:0];
    end
  end

  // Reassemble the full products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ab_sum <= {ab_hh, ab_ll}
              + (SUM_W'(ab_hl) << HALF_W)
              + (SUM_W'(ab_lh) << HALF_W);
      cc_sum <= {cc_hh, cc_ll} + (SUM_W'(cc_hl) << (HALF_W + 1));
    end
  end

  assign le = ab_sum <= cc_sum;

endmodule

// File: sv/voxel_shape_classifier.sv
// Voxel shape classifier: one voxel index (x, y, z) per beat goes in on the
// s_ side and one volume-memory write comes out on the m_ side, in order.
// The block is an eight-stage pipeline and takes a new voxel every cycle
// while the output is not stalled. Each stage holds its beat only while
// the stage after it is full and holding, so a stall on the output fills
// the empty stages before the input stops. The cylinder test splits its
// 40x40-bit product compare over two stages; that compare and the
// three-term fixed-point sums set the depth. Configuration is taken at any
// cycle through cfg_valid and must only change while the pipeline is empty.
module voxel_shape_classifier #(
  parameter int INDEX_BITS = vsc_pkg::INDEX_BITS_DEF,
  parameter int FRAC_BITS  = vsc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [vsc_pkg::IN_DATA_W-1:0]  s_tdata,   // voxel_x, voxel_y, voxel_z
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [vsc_pkg::OUT_DATA_W-1:0] m_tdata,   // write_enable, voxel_address,
                                                    // tag_value, status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vsc_pkg::*;

  localparam int NSTG  = 8;
  localparam int CEN_W = INDEX_BITS + FRAC_BITS + 1;
  localparam int D_W   = (CEN_W > COORD_BITS ? CEN_W : COORD_BITS) + 1;
  localparam int BX_W  = (CEN_W > COORD_BITS + 1 ? CEN_W : COORD_BITS + 1) + 1;
  localparam int DD_W  = 2 * D_W;
  localparam int VD_W  = COORD_BITS + D_W;
  localparam int VC_W  = COORD_BITS + CEN_W;
  localparam int SS_W  = DD_W + 2;
  localparam int T_W   = VD_W + 2;
  localparam int H_W   = VC_W + 2;
  localparam int MX_W  = (SS_W > T_W ? SS_W : T_W) > SCALAR_W ?
                         (SS_W > T_W ? SS_W : T_W) : SCALAR_W;
  localparam int CMP_W = (MX_W > H_W ? MX_W : H_W) + 1;
  localparam int AP_W  = INDEX_BITS + DIM_BITS + 1;
  localparam int AQ_W  = AP_W + DIM_BITS + 1;

  typedef struct packed {
    logic outgrid;
    logic box_hit;
    logic sph_in;
    logic hs_in;
    logic degen;
    logic cyl_ok;
    logic e_le0;
    logic e_gt;
  } flags_t;

  typedef struct packed {
    flags_t              f;
    logic [ADDR_W-1:0]   addr;
  } carry_t;

  // Configuration registers
  logic [KIND_W-1:0]   shape_kind;
  logic [VEC_W-1:0]    shape_anchor;
  logic [VEC_W-1:0]    shape_vector;
  logic [SCALAR_W-1:0] shape_scalar;
  logic [TAG_W-1:0]    fill_tag;
  logic [DIMS_W-1:0]   grid_dims;
  logic                row_major;

  assign cfg_ready = 1'b1;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind   <= '0;
      shape_anchor <= '0;
      shape_vector <= '0;
      shape_scalar <= '0;
      fill_tag     <= '0;
      grid_dims    <= '0;
      row_major    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KIND:   shape_kind   <= cfg_data[KIND_W-1:0];
        REG_ANCHOR: shape_anchor <= cfg_data[VEC_W-1:0];
        REG_VECTOR: shape_vector <= cfg_data[VEC_W-1:0];
        REG_SCALAR: shape_scalar <= cfg_data[SCALAR_W-1:0];
        REG_TAG:    fill_tag     <= cfg_data[TAG_W-1:0];
        REG_DIMS:   grid_dims    <= cfg_data[DIMS_W-1:0];
        REG_ORDER:  row_major    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Unpack configuration per axis
  logic signed [COORD_BITS-1:0] anc [3];
  logic signed [COORD_BITS-1:0] vec [3];
  logic        [DIM_BITS-1:0]   dim [3];
  logic signed [SCALAR_W-1:0]   r2;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      anc[a] = $signed(shape_anchor[a*COORD_BITS +: COORD_BITS]);
      vec[a] = $signed(shape_vector[a*COORD_BITS +: COORD_BITS]);
      dim[a] = grid_dims[a*DIM_BITS +: DIM_BITS];
    end
    r2 = $signed(shape_scalar);
  end

  // Stage valids and load enables
  logic [NSTG:1] vld;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !vld[NSTG] || m_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_tvalid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: centres, offsets, box test, grid test, first address product
  logic [INDEX_BITS-1:0]    idx [3];
  logic signed [CEN_W-1:0]  cen [3];
  logic signed [CEN_W-1:0]  pos [3];
  logic signed [BX_W-1:0]   pt, lo, hi;
  logic                     box_c, grid_c;
  logic [AP_W-1:0]          ap_c;

  always_comb begin
    box_c  = 1'b1;
    grid_c = 1'b0;
    for (int a = 0; a < 3; a++) begin
      idx[a] = s_tdata[a*IN_FIELD_W +: INDEX_BITS];
      cen[a] = $signed({1'b0, idx[a], 1'b1, (FRAC_BITS - 1)'(0)});
      pos[a] = $signed({1'b0, idx[a], FRAC_BITS'(0)});
      pt = (shape_kind == KIND_BOX) ? BX_W'(cen[a]) : BX_W'(pos[a]);
      lo = BX_W'(anc[a]);
      hi = BX_W'(anc[a]) + BX_W'(vec[a]);
      if (pt < lo || pt > hi) box_c = 1'b0;
      if (DIM_BITS'(idx[a]) >= dim[a]) grid_c = 1'b1;
    end
    if (row_major) begin
      ap_c = AP_W'(idx[0]) * AP_W'(dim[1]) + AP_W'(idx[1]);
    end else begin
      ap_c = AP_W'(idx[2]) * AP_W'(dim[1]) + AP_W'(idx[1]);
    end
  end

  logic signed [CEN_W-1:0]  cen1 [3];
  logic signed [D_W-1:0]    d1   [3];
  logic [AP_W-1:0]          ap1;
  logic [INDEX_BITS-1:0]    last1;
  logic                     box1, grid1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        cen1[a] <= cen[a];
        d1[a]   <= D_W'(cen[a]) - D_W'(anc[a]);
      end
      ap1   <= ap_c;
      last1 <= row_major ? idx[2] : idx[0];
      box1  <= box_c;
      grid1 <= grid_c;
    end
  end

  // Stage 2: per-axis products, final address
  logic signed [DD_W-1:0]         dd2 [3];
  logic signed [VD_W-1:0]         vd2 [3];
  logic signed [L2_W-1:0]         vv2 [3];
  logic signed [VC_W-1:0]         vc2 [3];
  logic [ADDR_W-1:0]              addr2;
  logic                           box2, grid2;
  logic [DIM_BITS-1:0]            dlast;

  assign dlast = row_major ? dim[2] : dim[0];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int a = 0; a < 3; a++) begin
        dd2[a] <= DD_W'(d1[a]) * DD_W'(d1[a]);
        vd2[a] <= VD_W'(vec[a]) * VD_W'(d1[a]);
        vv2[a] <= L2_W'(vec[a]) * L2_W'(vec[a]);
        vc2[a] <= VC_W'(vec[a]) * VC_W'(cen1[a]);
      end
      addr2 <= ADDR_W'(AQ_W'(ap1) * AQ_W'(dlast) + AQ_W'(last1));
      box2  <= box1;
      grid2 <= grid1;
    end
  end

  // Stage 3: three-term sums
  logic signed [SS_W-1:0] ss3;
  logic signed [T_W-1:0]  t3;
  logic [L2_W-1:0]        l23;
  logic signed [H_W-1:0]  hs3;
  logic [ADDR_W-1:0]      addr3;
  logic                   box3, grid3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ss3   <= SS_W'(dd2[0]) + SS_W'(dd2[1]) + SS_W'(dd2[2]);
      t3    <= T_W'(vd2[0]) + T_W'(vd2[1]) + T_W'(vd2[2]);
      l23   <= $unsigned(vv2[0]) + $unsigned(vv2[1]) + $unsigned(vv2[2]);
      hs3   <= H_W'(vc2[0]) + H_W'(vc2[1]) + H_W'(vc2[2]);
      addr3 <= addr2;
      box3  <= box2;
      grid3 <= grid2;
    end
  end

  // Stage 4: sphere and plane compares, axis range, cylinder excess
  logic signed [CMP_W-1:0] l2s3, r2s;
  carry_t                  c4;
  logic signed [CMP_W-1:0] e4;
  logic [L2_W-1:0]         t4, l24;

  assign l2s3 = CMP_W'($signed({1'b0, l23}));
  assign r2s  = CMP_W'(r2);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      c4.f.outgrid <= grid3;
      c4.f.box_hit <= box3;
      c4.f.sph_in  <= CMP_W'(ss3) <= r2s;
      c4.f.hs_in   <= CMP_W'(hs3) > r2s;
      c4.f.degen   <= l23 == '0;
      c4.f.cyl_ok  <= (t3 >= 0) && (CMP_W'(t3) <= l2s3) && (r2 >= 0);
      c4.f.e_le0   <= 1'b0;
      c4.f.e_gt    <= 1'b0;
      c4.addr      <= addr3;
      e4  <= CMP_W'(ss3) - r2s;
      t4  <= t3[L2_W-1:0];
      l24 <= l23;
    end
  end

  // Stage 5: bound the excess so both products fit 40 by 40 bits
  carry_t          c5, c5_next;
  logic [L2_W-1:0] e5, t5, l25;

  always_comb begin
    c5_next         = c4;
    c5_next.f.e_le0 = e4 <= 0;
    c5_next.f.e_gt  = e4 > CMP_W'($signed({1'b0, l24}));
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      c5  <= c5_next;
      e5  <= e4[L2_W-1:0];
      t5  <= t4;
      l25 <= l24;
    end
  end

  // Stages 6 and 7: excess * L2 against t * t
  logic   prod_le;
  carry_t c6, c7;

  vsc_prod_cmp u_prod_cmp (
    .clk (clk),
    .en  (en[7:6]),
    .a   (e5),
    .b   (l25),
    .c   (t5),
    .le  (prod_le)
  );

  always_ff @(posedge clk) begin
    if (en[6]) c6 <= c5;
    if (en[7]) c7 <= c6;
  end

  // Stage 8: select status and hold the output beat
  logic [STATUS_W-1:0] status_c;

  always_comb begin
    status_c = ST_OUTSIDE;
    if (c7.f.outgrid) begin
      status_c = ST_OUTGRID;
    end else begin
      unique case (shape_kind) inside
        KIND_SPHERE:           status_c = c7.f.sph_in ? ST_INSIDE : ST_OUTSIDE;
        KIND_BOX, KIND_SUBGRID: status_c = c7.f.box_hit ? ST_INSIDE : ST_OUTSIDE;
        KIND_CYL: begin
          if (c7.f.degen) begin
            status_c = ST_DEGEN;
          end else if (c7.f.cyl_ok && (c7.f.e_le0 || (!c7.f.e_gt && prod_le))) begin
            status_c = ST_INSIDE;
          end else begin
            status_c = ST_OUTSIDE;
          end
        end
        KIND_HALF:             status_c = c7.f.hs_in ? ST_INSIDE : ST_OUTSIDE;
        default:               status_c = ST_OUTSIDE;
      endcase
    end
  end

  logic                we8;
  logic [ADDR_W-1:0]   addr8;
  logic [TAG_W-1:0]    tag8;
  logic [STATUS_W-1:0] status8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      we8     <= status_c == ST_INSIDE;
      addr8   <= c7.addr;
      tag8    <= fill_tag;
      status8 <= status_c;
    end
  end

  assign m_tvalid = vld[NSTG];
  assign m_tdata  = {(OUT_DATA_W - 1 - ADDR_W - TAG_W - STATUS_W)'(0),
                     status8, tag8, addr8, we8};

  // Checks
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[1])
    else $error("accepted beat not captured in first stage");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (vld[1] && !en[2]))
    else $error("input stalled while first stage can drain");

  a_degen_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status8 == ST_DEGEN) |-> shape_kind == KIND_CYL)
    else $error("degenerate axis reported for non-cylinder");

  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && we8) |-> status8 == ST_INSIDE)
    else $error("write enable without inside status");

endmodule
